### rtl/xcp_pkg.sv
// Package for the XCP slave command engine: window sizes, command and error
// codes, register map and derived widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xcp_pkg;

   localparam int FLASH_WINDOW_BYTES = 1024;
   localparam int RAM_WINDOW_BYTES   = 1024;
   localparam int CMD_PACKET_BYTES   = 8;
   localparam int RES_PACKET_BYTES   = 8;

   localparam int FLASH_AW = $clog2(FLASH_WINDOW_BYTES);
   localparam int RAM_AW   = $clog2(RAM_WINDOW_BYTES);
   localparam int MAX_AW   = (FLASH_AW > RAM_AW) ? FLASH_AW : RAM_AW;
   localparam int MAX_WINDOW_BYTES =
      (FLASH_WINDOW_BYTES > RAM_WINDOW_BYTES) ? FLASH_WINDOW_BYTES : RAM_WINDOW_BYTES;
   localparam int OFF_SUM_BITS = MAX_AW + 1;
   localparam int IDX_BITS     = $clog2(CMD_PACKET_BYTES);

   typedef logic [7:0] byte_type;

   localparam byte_type PID_IGNORE     = 8'hAA;
   localparam byte_type PID_CONNECT    = 8'hFF;
   localparam byte_type PID_DISCONNECT = 8'hFE;
   localparam byte_type PID_GET_STATUS = 8'hFD;
   localparam byte_type PID_SYNCH      = 8'hFC;
   localparam byte_type PID_SET_MTA    = 8'hF6;
   localparam byte_type PID_UPLOAD     = 8'hF5;
   localparam byte_type PID_DOWNLOAD   = 8'hF0;

   localparam byte_type RES_POS      = 8'hFF;
   localparam byte_type RES_NEG      = 8'hFE;
   localparam byte_type ERR_UNKNOWN  = 8'h20;
   localparam byte_type ERR_RANGE    = 8'h22;
   localparam byte_type CONN_RESOURCE = 8'h20;
   localparam byte_type CONN_COMM_MODE = 8'h00;

   localparam byte_type UPLOAD_MAX_LEN   = byte_type'(RES_PACKET_BYTES - 1);
   localparam byte_type DOWNLOAD_MAX_LEN = byte_type'(CMD_PACKET_BYTES - 2);

   localparam int CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_FLASH_START = 2'd0;
   localparam logic [1:0] REG_RAM_START   = 2'd1;
   localparam logic [1:0] REG_PROTO_VER   = 2'd2;
   localparam logic [1:0] REG_TRANS_VER   = 2'd3;

   localparam logic [31:0] FLASH_START_RESET = 32'h0800_0000;
   localparam logic [31:0] RAM_START_RESET   = 32'h2000_0000;
   localparam byte_type    PROTO_VER_RESET   = 8'd1;
   localparam byte_type    TRANS_VER_RESET   = 8'd1;

   localparam logic WIN_FLASH = 1'b0;
   localparam logic WIN_RAM   = 1'b1;

endpackage

`default_nettype wire

### rtl/xcp_byte_ram.sv
// Single-port byte RAM with registered read data; backs one memory window.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module xcp_byte_ram #(
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [7:0]           wdata,
   output logic [7:0]           rdata
);

   logic [7:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

### rtl/xcp_slave_command_engine.sv
// XCP slave command engine top level: sequencer, shared 32-bit add/subtract
// unit, transfer address, CSRs and response register. Uses xcp_pkg, xcp_byte_ram.
// IGNORE gives no response; CONNECT, DISCONNECT, GET_STATUS, SYNCH and unknown PIDs
// skip the window checks; UPLOAD/DOWNLOAD transfer one byte per cycle after them.
// One transaction at a time; the next is taken in the cycle after the response loads.
// Reset: CSRs to defaults, then a clearing pass zeroes both windows.
`timescale 1ns / 1ps
`default_nettype none

module xcp_slave_command_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  xcp_pkg::byte_type                 req_cmd_pid,
   input  xcp_pkg::byte_type                 req_cmd_b1,
   input  xcp_pkg::byte_type                 req_cmd_b2,
   input  xcp_pkg::byte_type                 req_cmd_b3,
   input  xcp_pkg::byte_type                 req_cmd_b4,
   input  xcp_pkg::byte_type                 req_cmd_b5,
   input  xcp_pkg::byte_type                 req_cmd_b6,
   input  xcp_pkg::byte_type                 req_cmd_b7,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output xcp_pkg::byte_type                 rsp_res_pid,
   output xcp_pkg::byte_type                 rsp_res_b1,
   output xcp_pkg::byte_type                 rsp_res_b2,
   output xcp_pkg::byte_type                 rsp_res_b3,
   output xcp_pkg::byte_type                 rsp_res_b4,
   output xcp_pkg::byte_type                 rsp_res_b5,
   output xcp_pkg::byte_type                 rsp_res_b6,
   output xcp_pkg::byte_type                 rsp_res_b7,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xcp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   import xcp_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_CHKF  = 7'b0000100,
      S_CHKR  = 7'b0001000,
      S_XFER  = 7'b0010000,
      S_ADV   = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   localparam logic [MAX_AW-1:0] CLR_LAST = MAX_AW'(MAX_WINDOW_BYTES - 1);

   state_type             state_ff, state_in;
   logic [MAX_AW-1:0]     clr_ff, clr_in;
   logic [31:0]           ta_ff, ta_in;
   logic [31:0]           chk_ff, chk_in;
   byte_type              pid_ff, pid_in;
   byte_type              len_ff, len_in;
   byte_type              cmd_ff [CMD_PACKET_BYTES];
   byte_type              cmd_in [CMD_PACKET_BYTES];
   byte_type              res_ff [RES_PACKET_BYTES];
   byte_type              res_in [RES_PACKET_BYTES];
   logic                  win_ff, win_in;
   logic [MAX_AW-1:0]     off_ff, off_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  cap_vld_ff, cap_vld_in;
   logic [IDX_BITS-1:0]   cap_slot_ff, cap_slot_in;
   logic                  cap_inwin_ff, cap_inwin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              rsp_ff [RES_PACKET_BYTES];

   logic [31:0]           flash_start_ff, ram_start_ff;
   byte_type              proto_ver_ff, trans_ver_ff;

   logic                  req_acc, csr_wr, rsp_load;
   logic [31:0]           unit_a, unit_b, unit_sum;
   logic                  unit_sub, hit_now, len_ok, is_upload;
   logic                  xfer_go, xfer_inwin, clearing;
   logic [OFF_SUM_BITS-1:0] acc_sum;
   logic                  flash_we, ram_we;
   logic [FLASH_AW-1:0]   flash_addr;
   logic [RAM_AW-1:0]     ram_addr;
   byte_type              wr_data, flash_rdata, ram_rdata, rd_byte;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // shared add/subtract unit
   always_comb begin
      unit_a   = chk_ff;
      unit_b   = {24'd0, len_ff};
      unit_sub = 1'b0;
      priority if (state_ff == S_CHKF) begin
         unit_b   = flash_start_ff;
         unit_sub = 1'b1;
      end else if (state_ff == S_CHKR) begin
         unit_b   = ram_start_ff;
         unit_sub = 1'b1;
      end else begin
         unit_a = ta_ff;
      end
   end

   assign unit_sum = unit_a + (unit_b ^ {32{unit_sub}}) + {31'd0, unit_sub};
   assign hit_now  = (state_ff == S_CHKF) ? (unit_sum < 32'(FLASH_WINDOW_BYTES))
                                          : (unit_sum < 32'(RAM_WINDOW_BYTES));
   assign is_upload = (pid_ff == PID_UPLOAD);
   assign len_ok    = is_upload ? (len_ff <= UPLOAD_MAX_LEN) : (len_ff <= DOWNLOAD_MAX_LEN);

   // byte transfer addressing
   assign clearing   = (state_ff == S_CLEAR);
   assign xfer_go    = (state_ff == S_XFER) && (idx_ff < len_ff[IDX_BITS-1:0]);
   assign acc_sum    = {1'b0, off_ff} + OFF_SUM_BITS'(idx_ff);
   assign xfer_inwin = (win_ff == WIN_FLASH) ? (acc_sum < OFF_SUM_BITS'(FLASH_WINDOW_BYTES))
                                             : (acc_sum < OFF_SUM_BITS'(RAM_WINDOW_BYTES));
   assign wr_data    = clearing ? 8'd0 : cmd_ff[idx_ff + IDX_BITS'(2)];
   assign flash_addr = clearing ? clr_ff[FLASH_AW-1:0] : acc_sum[FLASH_AW-1:0];
   assign ram_addr   = clearing ? clr_ff[RAM_AW-1:0] : acc_sum[RAM_AW-1:0];
   assign flash_we   = (clearing && ({1'b0, clr_ff} < OFF_SUM_BITS'(FLASH_WINDOW_BYTES)))
                    || (xfer_go && !is_upload && xfer_inwin && (win_ff == WIN_FLASH));
   assign ram_we     = (clearing && ({1'b0, clr_ff} < OFF_SUM_BITS'(RAM_WINDOW_BYTES)))
                    || (xfer_go && !is_upload && xfer_inwin && (win_ff == WIN_RAM));
   assign rd_byte    = (win_ff == WIN_FLASH) ? flash_rdata : ram_rdata;

   xcp_byte_ram #(.ADDR_BITS(FLASH_AW)) u_flash_ram (
      .clock (clock),
      .we    (flash_we),
      .addr  (flash_addr),
      .wdata (wr_data),
      .rdata (flash_rdata)
   );

   xcp_byte_ram #(.ADDR_BITS(RAM_AW)) u_ram_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (wr_data),
      .rdata (ram_rdata)
   );

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ta_in        = ta_ff;
      chk_in       = chk_ff;
      pid_in       = pid_ff;
      len_in       = len_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      win_in       = win_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      cap_vld_in   = xfer_go && is_upload;
      cap_slot_in  = idx_ff;
      cap_inwin_in = xfer_inwin;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + MAX_AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in = '{req_cmd_pid, req_cmd_b1, req_cmd_b2, req_cmd_b3,
                          req_cmd_b4, req_cmd_b5, req_cmd_b6, req_cmd_b7};
               pid_in = req_cmd_pid;
               len_in = req_cmd_b1;
               chk_in = (req_cmd_pid == PID_SET_MTA)
                      ? {req_cmd_b7, req_cmd_b6, req_cmd_b5, req_cmd_b4} : ta_ff;
               res_in = '{default: 8'd0};
               unique case (req_cmd_pid)
                  PID_IGNORE: begin
                     state_in = S_IDLE;
                  end
                  PID_CONNECT: begin
                     res_in[0] = RES_POS;
                     res_in[1] = CONN_RESOURCE;
                     res_in[2] = byte_type'(CMD_PACKET_BYTES);
                     res_in[3] = CONN_COMM_MODE;
                     res_in[4] = byte_type'(RES_PACKET_BYTES);
                     res_in[5] = proto_ver_ff;
                     res_in[6] = trans_ver_ff;
                     state_in  = S_RESP;
                  end
                  PID_DISCONNECT, PID_GET_STATUS, PID_SYNCH: begin
                     res_in[0] = RES_POS;
                     state_in  = S_RESP;
                  end
                  PID_SET_MTA, PID_UPLOAD, PID_DOWNLOAD: begin
                     state_in = S_CHKF;
                  end
                  default: begin
                     res_in[0] = RES_NEG;
                     res_in[1] = ERR_UNKNOWN;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_CHKF, S_CHKR: begin
            priority if (hit_now) begin
               win_in = (state_ff == S_CHKF) ? WIN_FLASH : WIN_RAM;
               off_in = unit_sum[MAX_AW-1:0];
               priority if (pid_ff == PID_SET_MTA) begin
                  ta_in     = chk_ff;
                  res_in[0] = RES_POS;
                  state_in  = S_RESP;
               end else if (len_ok) begin
                  res_in[0] = RES_POS;
                  idx_in    = '0;
                  state_in  = S_XFER;
               end else begin
                  res_in[0] = RES_NEG;
                  res_in[1] = ERR_RANGE;
                  state_in  = S_RESP;
               end
            end else if (state_ff == S_CHKF) begin
               state_in = S_CHKR;
            end else begin
               res_in[0] = RES_NEG;
               res_in[1] = ERR_RANGE;
               state_in  = S_RESP;
            end
         end
         S_XFER: begin
            if (xfer_go) begin
               idx_in = idx_ff + IDX_BITS'(1);
            end else begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            ta_in    = unit_sum;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // land upload read data in the cycle after the read
      if (cap_vld_ff) begin
         res_in[cap_slot_ff + IDX_BITS'(1)] = cap_inwin_ff ? rd_byte : 8'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ta_ff        <= '0;
         cap_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ta_ff        <= ta_in;
         cap_vld_ff   <= cap_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff       <= chk_in;
      pid_ff       <= pid_in;
      len_ff       <= len_in;
      cmd_ff       <= cmd_in;
      res_ff       <= res_in;
      win_ff       <= win_in;
      off_ff       <= off_in;
      idx_ff       <= idx_in;
      cap_slot_ff  <= cap_slot_in;
      cap_inwin_ff <= cap_inwin_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_start_ff <= FLASH_START_RESET;
         ram_start_ff   <= RAM_START_RESET;
         proto_ver_ff   <= PROTO_VER_RESET;
         trans_ver_ff   <= TRANS_VER_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_FLASH_START: flash_start_ff <= csr_pwdata;
            REG_RAM_START:   ram_start_ff   <= csr_pwdata;
            REG_PROTO_VER:   proto_ver_ff   <= csr_pwdata[7:0];
            REG_TRANS_VER:   trans_ver_ff   <= csr_pwdata[7:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_FLASH_START: csr_prdata = flash_start_ff;
         REG_RAM_START:   csr_prdata = ram_start_ff;
         REG_PROTO_VER:   csr_prdata = {24'd0, proto_ver_ff};
         REG_TRANS_VER:   csr_prdata = {24'd0, trans_ver_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_pid = rsp_ff[0];
   assign rsp_res_b1  = rsp_ff[1];
   assign rsp_res_b2  = rsp_ff[2];
   assign rsp_res_b3  = rsp_ff[3];
   assign rsp_res_b4  = rsp_ff[4];
   assign rsp_res_b5  = rsp_ff[5];
   assign rsp_res_b6  = rsp_ff[6];
   assign rsp_res_b7  = rsp_ff[7];

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");

   a_ram_write_phase: assert property (@(posedge clock) disable iff (reset)
      (flash_we || ram_we) |-> (state_ff == S_CLEAR || state_ff == S_XFER))
      else $error("window write outside clear pass or transfer");

   a_ta_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(ta_ff))
      |-> $past(state_ff == S_ADV || state_ff == S_CHKF || state_ff == S_CHKR))
      else $error("transfer address changed outside check or advance");

   a_ignore_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_cmd_pid == PID_IGNORE) |=> (state_ff == S_IDLE))
      else $error("ignore marker did not return to idle");

endmodule

`default_nettype wire
